// ===== rtl/rpn_pkg.sv =====
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int LIM_W       = (SP_W > 8) ? SP_W : 8;

  localparam logic [7:0] LIMIT_RESET = 8'd128;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // iterative divider: 48-bit dividend (Q16.16 value shifted up), 32-bit divisor
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW);

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_SUB     = 3'd2,
    CMD_MUL     = 3'd3,
    CMD_DIV     = 3'd4,
    CMD_MOD     = 3'd5,
    CMD_PRINT   = 3'd6,
    CMD_UNKNOWN = 3'd7
  } rpn_cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ZERO    = 3'd3,
    ST_OVF     = 3'd4,
    ST_UNKNOWN = 3'd5
  } rpn_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POPB,
    S_GETB,
    S_POPA,
    S_GETA,
    S_EXEC,
    S_MULSAT,
    S_DIV,
    S_PUSH,
    S_DONE
  } rpn_state_e;

  typedef struct packed {
    rpn_cmd_e    cmd;
    logic        pops_one;
    logic        pops_two;
    logic [31:0] operand;
  } rpn_item_t;

  typedef struct packed {
    rpn_status_e status;
    logic        print_valid;
    logic [31:0] print_value;
    logic [7:0]  depth;
  } rpn_result_t;

endpackage

`default_nettype wire

// ===== rtl/rpn_front.sv =====
`default_nettype none

module rpn_front (
  input  wire                logic        in_valid_i,
  output                     logic        in_stall_o,
  input  wire                logic [2:0]  command_i,
  input  wire  logic signed  [31:0]       operand_value_i,
  input  wire                logic        fifo_full_i,
  output                     logic        fifo_push_o,
  output rpn_pkg::rpn_item_t              item_o
);
  import rpn_pkg::*;

  rpn_cmd_e cmd;

  assign cmd         = rpn_cmd_e'(command_i);
  assign in_stall_o  = fifo_full_i;
  assign fifo_push_o = in_valid_i & ~fifo_full_i;

  // classify by how many stack entries the token consumes
  always_comb begin
    item_o.cmd      = cmd;
    item_o.operand  = operand_value_i;
    item_o.pops_one = 1'b0;
    item_o.pops_two = 1'b0;
    case (cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
        item_o.pops_two = 1'b1;
      end
      CMD_PRINT: begin
        item_o.pops_one = 1'b1;
      end
      default: begin
        item_o.pops_one = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rpn_fifo.sv =====
`default_nettype none

module rpn_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rpn_pkg::rpn_item_t item_i,
  output      logic               full_o,
  input  wire logic               pop_i,
  output      logic               empty_o,
  output      rpn_pkg::rpn_item_t item_o
);
  import rpn_pkg::*;

  rpn_item_t            entry_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpn_div.sv =====
`default_nettype none

module rpn_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rpn_pkg::DIV_NW-1:0] dividend_i,
  input  wire logic [rpn_pkg::DIV_DW-1:0] divisor_i,
  output      logic                       done_o,
  output      logic [rpn_pkg::DIV_NW-1:0] quotient_o,
  output      logic [rpn_pkg::DIV_DW-1:0] remainder_o
);
  import rpn_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] dsr_q, dsr_d;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] diff;
  logic              ge;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem_q, quo_q[DIV_NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge      = ~diff[DIV_DW+1];

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_NW-2:0], ge};
      rem_d = ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

endmodule

`default_nettype wire

// ===== rtl/rpn_back.sv =====
`default_nettype none

module rpn_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [7:0]           cfg_wdata_i,
  input  wire logic                 fifo_empty_i,
  input  wire rpn_pkg::rpn_item_t   item_i,
  output      logic                 fifo_pop_o,
  input  wire logic                 out_stall_i,
  output      logic                 out_valid_o,
  output      rpn_pkg::rpn_result_t result_o
);
  import rpn_pkg::*;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  function automatic rpn_status_e raise(rpn_status_e cur, rpn_status_e code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  // Q16.16 to integer, truncated toward zero
  function automatic logic [15:0] trunc16(logic [31:0] x);
    return x[31:16] + {15'b0, (x[31] & (|x[15:0]))};
  endfunction

  function automatic logic [15:0] abs16(logic [15:0] x);
    return x[15] ? (~x + 16'd1) : x;
  endfunction

  function automatic logic [31:0] abs32(logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  rpn_state_e         state_q, state_d;
  logic [SP_W-1:0]    sp_q, sp_d;
  logic [7:0]         limit_q;
  logic               out_valid_q, out_valid_d;
  rpn_result_t        res_q, res_d;

  rpn_item_t          item_q, item_d;
  rpn_status_e        st_q, st_d;
  logic               pop_ok_q, pop_ok_d;
  logic signed [31:0] a_q, a_d;
  logic signed [31:0] b_q, b_d;
  logic signed [31:0] val_q, val_d;
  logic signed [63:0] prod_q, prod_d;
  logic               pvalid_q, pvalid_d;
  logic [31:0]        pval_q, pval_d;

  logic [31:0]        mem [STACK_DEPTH];
  logic [31:0]        rd_q;
  logic [STK_AW-1:0]  rd_addr;
  logic               mem_we;

  logic [LIM_W-1:0]   lim;
  logic               push_room;
  logic [31:0]        pop_data;
  logic [32:0]        sum;
  logic [47:0]        mul_sh;
  logic               div_start, div_done;
  logic [DIV_NW-1:0]  div_dividend, div_quo;
  logic [DIV_DW-1:0]  div_divisor, div_rem;
  logic               neg;

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  assign rd_addr     = STK_AW'(sp_q - 1'b1);
  assign pop_data    = pop_ok_q ? rd_q : 32'd0;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    lim = LIM_W'(limit_q);
    if (limit_q == 8'd0) begin
      lim = LIM_W'(1);
    end
    if (lim > LIM_W'(STACK_DEPTH)) begin
      lim = LIM_W'(STACK_DEPTH);
    end
  end
  assign push_room = (LIM_W'(sp_q) < lim);

  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    out_valid_d  = out_valid_q & out_stall_i;
    res_d        = res_q;
    item_d       = item_q;
    st_d         = st_q;
    pop_ok_d     = pop_ok_q;
    a_d          = a_q;
    b_d          = b_q;
    val_d        = val_q;
    prod_d       = prod_q;
    pvalid_d     = pvalid_q;
    pval_d       = pval_q;
    fifo_pop_o   = 1'b0;
    mem_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    sum          = '0;
    mul_sh       = prod_q[63:16];
    neg          = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          item_d     = item_i;
          st_d       = ST_OK;
          pvalid_d   = 1'b0;
          pval_d     = 32'd0;
          if (item_i.pops_one || item_i.pops_two) begin
            state_d = S_POPB;
          end else if (item_i.cmd == CMD_PUSH) begin
            val_d   = item_i.operand;
            state_d = S_PUSH;
          end else begin
            st_d    = ST_UNKNOWN;
            state_d = S_DONE;
          end
        end
      end

      S_POPB, S_POPA: begin
        pop_ok_d = (sp_q != '0);
        if (sp_q != '0) begin
          sp_d = sp_q - 1'b1;
        end else begin
          st_d = raise(st_q, ST_EMPTY);
        end
        state_d = (state_q == S_POPB) ? S_GETB : S_GETA;
      end

      S_GETB: begin
        b_d     = pop_data;
        state_d = S_POPA;
        case (item_q.cmd)
          CMD_PRINT: begin
            pvalid_d = 1'b1;
            pval_d   = pop_data;
            state_d  = S_DONE;
          end
          CMD_DIV: begin
            if (pop_data == 32'd0) begin
              st_d    = raise(st_q, ST_ZERO);
              state_d = S_DONE;
            end
          end
          CMD_MOD: begin
            if (trunc16(pop_data) == 16'd0) begin
              st_d    = raise(st_q, ST_ZERO);
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_POPA;
          end
        endcase
      end

      S_GETA: begin
        a_d     = pop_data;
        state_d = S_EXEC;
      end

      S_EXEC: begin
        state_d = S_PUSH;
        case (item_q.cmd)
          CMD_ADD, CMD_SUB: begin
            if (item_q.cmd == CMD_ADD) begin
              sum = {a_q[31], a_q} + {b_q[31], b_q};
            end else begin
              sum = {a_q[31], a_q} - {b_q[31], b_q};
            end
            if (sum[32] != sum[31]) begin
              st_d  = raise(st_q, ST_OVF);
              val_d = sum[32] ? SAT_MIN : SAT_MAX;
            end else begin
              val_d = sum[31:0];
            end
          end
          CMD_MUL: begin
            prod_d  = a_q * b_q;
            state_d = S_MULSAT;
          end
          CMD_DIV: begin
            div_start    = 1'b1;
            div_dividend = {abs32(a_q), 16'd0};
            div_divisor  = abs32(b_q);
            state_d      = S_DIV;
          end
          CMD_MOD: begin
            div_start    = 1'b1;
            div_dividend = DIV_NW'(abs16(trunc16(a_q)));
            div_divisor  = DIV_DW'(abs16(trunc16(b_q)));
            state_d      = S_DIV;
          end
          default: begin
            state_d = S_PUSH;
          end
        endcase
      end

      S_MULSAT: begin
        // arithmetic shift of the product floors toward minus infinity
        if (mul_sh[47:31] != {17{mul_sh[47]}}) begin
          st_d  = raise(st_q, ST_OVF);
          val_d = mul_sh[47] ? SAT_MIN : SAT_MAX;
        end else begin
          val_d = mul_sh[31:0];
        end
        state_d = S_PUSH;
      end

      S_DIV: begin
        if (div_done) begin
          state_d = S_PUSH;
          if (item_q.cmd == CMD_MOD) begin
            // remainder takes the dividend's sign
            neg = a_q[31];
            val_d = neg ? -{div_rem[15:0], 16'd0} : {div_rem[15:0], 16'd0};
          end else begin
            neg = a_q[31] ^ b_q[31];
            if (!neg && div_quo > DIV_NW'(32'h7FFF_FFFF)) begin
              st_d  = raise(st_q, ST_OVF);
              val_d = SAT_MAX;
            end else if (neg && div_quo > DIV_NW'(32'h8000_0000)) begin
              st_d  = raise(st_q, ST_OVF);
              val_d = SAT_MIN;
            end else begin
              val_d = neg ? -div_quo[31:0] : div_quo[31:0];
            end
          end
        end
      end

      S_PUSH: begin
        if (push_room) begin
          mem_we = 1'b1;
          sp_d   = sp_q + 1'b1;
        end else begin
          st_d = raise(st_q, ST_FULL);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          res_d.status      = st_q;
          res_d.print_valid = pvalid_q;
          res_d.print_value = pval_q;
          res_d.depth       = 8'(sp_q);
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    item_q   <= item_d;
    st_q     <= st_d;
    pop_ok_q <= pop_ok_d;
    a_q      <= a_d;
    b_q      <= b_d;
    val_q    <= val_d;
    prod_q   <= prod_d;
    pvalid_q <= pvalid_d;
    pval_q   <= pval_d;
  end

  // stack memory, registered read at the entry below the pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[sp_q[STK_AW-1:0]] <= val_q;
    end
    rd_q <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/rpn_stack_calculator_core.sv =====
// Each token runs the back-end state machine: unknown goes straight to the result, push
// writes the stack, print pops one entry, add/subtract pop two and execute, multiply adds
// a saturation step and divide/modulo wait for the 48-step serial divider.
// One item is executed at a time while the two-entry queue takes further tokens; a further
// item starts only after the last result is handed to the output. Reset clears the stack
// pointer, queue and output valid flag and sets the limit to 128; stack memory is not cleared.
`default_nettype none

module rpn_stack_calculator_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [2:0]         command_i,
  input  wire logic signed [31:0] operand_value_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [2:0]         status_o,
  output      logic               print_valid_o,
  output      logic signed [31:0] print_value_o,
  output      logic [7:0]         stack_depth_o
);
  import rpn_pkg::*;

  rpn_item_t   front_item, queue_item;
  rpn_result_t result;
  logic        fifo_full, fifo_empty, fifo_push, fifo_pop;

  rpn_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .operand_value_i(operand_value_i),
    .fifo_full_i    (fifo_full),
    .fifo_push_o    (fifo_push),
    .item_o         (front_item)
  );

  rpn_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .item_i (front_item),
    .full_o (fifo_full),
    .pop_i  (fifo_pop),
    .empty_o(fifo_empty),
    .item_o (queue_item)
  );

  rpn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fifo_empty_i(fifo_empty),
    .item_i      (queue_item),
    .fifo_pop_o  (fifo_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign status_o      = result.status;
  assign print_valid_o = result.print_valid;
  assign print_value_o = result.print_value;
  assign stack_depth_o = result.depth;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stack_depth_o <= 8'(STACK_DEPTH)))
    else $error("stack depth beyond capacity");

  a_print_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && print_valid_o) |-> (status_o == ST_OK || status_o == ST_EMPTY))
    else $error("print reported an impossible status");

  a_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !print_valid_o) |-> (print_value_o == 32'sd0))
    else $error("print value set on a non-print result");
`endif

endmodule

`default_nettype wire
